[sv/pcxd_pkg.sv]
// ----------------------------------------------------------------------------
// pcxd_pkg
// Shared types, constants and pixel packing for the PCX scanline decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pcxd_pkg;

  localparam int unsigned MaxBytesPerLine = 1024;
  localparam int unsigned ColW            = $clog2(MaxBytesPerLine);
  localparam int unsigned LenW            = ColW + 1;

  localparam logic [7:0]      RUN_MARK  = 8'hC0;
  localparam logic [7:0]      RUN_COUNT = 8'h3F;
  localparam logic [7:0]      FULL_BYTE = 8'hFF;
  localparam logic [LenW-1:0] LEN_MIN   = LenW'(1);
  localparam logic [LenW-1:0] LEN_MAX   = LenW'(MaxBytesPerLine);
  localparam logic [LenW-1:0] LEN_RESET = LenW'(80);

  localparam logic REG_BYTES_PER_LINE = 1'b0;
  localparam logic REG_PLANE_MODE     = 1'b1;

  localparam logic [1:0] MODE_CHUNKY  = 2'd0;
  localparam logic [1:0] MODE_PLANAR3 = 2'd1;
  localparam logic [1:0] MODE_PLANAR4 = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [31:0]     data;
    logic [ColW-1:0] column;
    logic [15:0]     line_index;
    logic            line_end;
    logic            overrun;
    logic            last;
  } result_t;

  function automatic logic [31:0] pack_pixels(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b, input logic [7:0] i);
    logic [31:0] word;
    word = '0;
    for (int k = 0; k < 8; k++) begin
      word[8*(k/2) + ((k % 2 == 0) ? 4 : 0) +: 4] = {i[7-k], b[7-k], g[7-k], r[7-k]};
    end
    return word;
  endfunction

endpackage

`default_nettype wire

[sv/pcxd_ram.sv]
// ----------------------------------------------------------------------------
// pcxd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/pcxd_out_stage.sv]
// ----------------------------------------------------------------------------
// pcxd_out_stage
// Output register holding one result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxd_out_stage
  import pcxd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire result_t         res,
  output logic                 free,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [31:0]          out_data,
  output logic [ColW-1:0]      out_column,
  output logic [15:0]          out_line_index,
  output logic                 out_line_end,
  output logic                 out_overrun,
  output logic                 out_last
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid      = valid_r;
  assign out_data       = res_r.data;
  assign out_column     = res_r.column;
  assign out_line_index = res_r.line_index;
  assign out_line_end   = res_r.line_end;
  assign out_overrun    = res_r.overrun;
  assign out_last       = res_r.last;

endmodule

`default_nettype wire

[sv/pcxd_seq.sv]
// ----------------------------------------------------------------------------
// pcxd_seq
// Run-length sequencer: steps one decoded byte at a time through the plane
// store and the pixel packer, tracking column, plane and scanline.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxd_seq
  import pcxd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic            cfg_index,
  input  wire logic [LenW-1:0] cfg_data,
  output logic                 rd_en,
  output logic [ColW-1:0]      mem_addr,
  output logic [2:0]           wr_en,
  output logic [7:0]           wr_data,
  input  wire logic [7:0]      rd_r,
  input  wire logic [7:0]      rd_g,
  input  wire logic [7:0]      rd_b,
  input  wire logic            out_free,
  output logic                 res_load,
  output result_t              res
);

  state_t          state_r, state_nxt;
  logic            pending_r, pending_nxt;
  logic [5:0]      run_len_r, run_len_nxt;
  logic [5:0]      reps_r, reps_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic [1:0]      plane_r, plane_nxt;
  logic [ColW-1:0] col_r, col_nxt;
  logic [15:0]     line_r, line_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [1:0]      mode_r, mode_nxt;

  logic [1:0]      last_plane;
  logic            is_last;
  logic            plane_end;
  logic            ended;
  logic            final_rep;
  logic            in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign mem_addr  = col_r;
  assign wr_data   = byte_r;
  assign rd_en     = (state_r == ST_READ);

  always_comb begin
    unique case (mode_r) inside
      MODE_CHUNKY:              last_plane = 2'd0;
      MODE_PLANAR3:             last_plane = 2'd2;
      MODE_PLANAR4, MODE_SPARE: last_plane = 2'd3;
      default:                  last_plane = 2'd3;
    endcase
  end

  assign is_last   = plane_r >= last_plane;
  assign plane_end = ({1'b0, col_r} + LenW'(1)) >= len_r;
  assign ended     = plane_end && is_last;
  assign final_rep = (reps_r == 6'd1) || ended;

  always_comb begin
    res.column     = col_r;
    res.line_index = line_r;
    res.line_end   = ended;
    res.overrun    = ended && (reps_r != 6'd1);
    res.last       = final_rep;
    case (mode_r)
      MODE_CHUNKY:  res.data = {24'd0, byte_r};
      MODE_PLANAR3: res.data = pack_pixels(rd_r, rd_g, byte_r, FULL_BYTE);
      default:      res.data = pack_pixels(rd_r, rd_g, rd_b, byte_r);
    endcase
  end

  always_comb begin
    len_nxt = len_r;
    mode_nxt = mode_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BYTES_PER_LINE: begin
          if (cfg_data == '0) begin
            len_nxt = LEN_MIN;
          end else if (cfg_data > LEN_MAX) begin
            len_nxt = LEN_MAX;
          end else begin
            len_nxt = cfg_data;
          end
        end
        REG_PLANE_MODE: mode_nxt = cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    pending_nxt = pending_r;
    run_len_nxt = run_len_r;
    reps_nxt    = reps_r;
    byte_nxt    = byte_r;
    plane_nxt   = plane_r;
    col_nxt     = col_r;
    line_nxt    = line_r;
    wr_en       = 3'b000;
    res_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          byte_nxt = in_byte;
          if (pending_r) begin
            pending_nxt = 1'b0;
            run_len_nxt = 6'd0;
            reps_nxt    = run_len_r;
            if (run_len_r != 6'd0) begin
              state_nxt = ST_READ;
            end
          end else if ((in_byte & RUN_MARK) == RUN_MARK) begin
            pending_nxt = 1'b1;
            run_len_nxt = in_byte[5:0] & RUN_COUNT[5:0];
          end else begin
            reps_nxt  = 6'd1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!is_last || out_free) begin
          if (is_last) begin
            res_load = 1'b1;
          end else begin
            wr_en[plane_r] = 1'b1;
          end
          reps_nxt = reps_r - 6'd1;
          if (plane_end) begin
            col_nxt = '0;
            if (is_last) begin
              plane_nxt = 2'd0;
              line_nxt  = line_r + 16'd1;
            end else begin
              plane_nxt = plane_r + 2'd1;
            end
          end else begin
            col_nxt = col_r + ColW'(1);
          end
          state_nxt = final_rep ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pending_r <= 1'b0;
      run_len_r <= 6'd0;
      reps_r    <= 6'd0;
      plane_r   <= 2'd0;
      col_r     <= '0;
      line_r    <= 16'd0;
      len_r     <= LEN_RESET;
      mode_r    <= MODE_CHUNKY;
    end else begin
      state_r   <= state_nxt;
      pending_r <= pending_nxt;
      run_len_r <= run_len_nxt;
      reps_r    <= reps_nxt;
      plane_r   <= plane_nxt;
      col_r     <= col_nxt;
      line_r    <= line_nxt;
      len_r     <= len_nxt;
      mode_r    <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

`default_nettype wire

[sv/pcx_rle_scanline_decoder.sv]
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder
// PCX run-length decoder producing chunky bytes or packed IRGB pixel words.
//
//   channel  ports                                   direction
//   in       in_valid/in_ready, in_byte              sink
//   out      out_valid/out_ready, out_data, out_*    source
//   cfg      cfg_valid/cfg_ready, cfg_index/cfg_data sink
//
// Each decoded byte takes a plane store read, then a store write or result
// load; a run header byte is taken while idle. in_ready is low while a literal
// or a run is in progress. A full output register stalls the sequencer only
// on last-plane bytes. Reset is synchronous; no clearing pass, the plane
// store is left as is.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_scanline_decoder
  import pcxd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [31:0]          out_data,
  output logic [ColW-1:0]      out_column,
  output logic [15:0]          out_line_index,
  output logic                 out_line_end,
  output logic                 out_overrun,
  output logic                 out_last,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic            cfg_index,
  input  wire logic [LenW-1:0] cfg_data
);

  logic            rd_en;
  logic [ColW-1:0] mem_addr;
  logic [2:0]      wr_en;
  logic [7:0]      wr_data;
  logic [7:0]      rd_r, rd_g, rd_b;
  logic            out_free;
  logic            res_load;
  result_t         res;

  pcxd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rd_en    (rd_en),
    .mem_addr (mem_addr),
    .wr_en    (wr_en),
    .wr_data  (wr_data),
    .rd_r     (rd_r),
    .rd_g     (rd_g),
    .rd_b     (rd_b),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  pcxd_ram #(.Width(8), .Depth(MaxBytesPerLine)) u_ram_r (
    .clk    (clk),
    .wr_en  (wr_en[0]),
    .wr_addr(mem_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(mem_addr),
    .rd_data(rd_r)
  );

  pcxd_ram #(.Width(8), .Depth(MaxBytesPerLine)) u_ram_g (
    .clk    (clk),
    .wr_en  (wr_en[1]),
    .wr_addr(mem_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(mem_addr),
    .rd_data(rd_g)
  );

  pcxd_ram #(.Width(8), .Depth(MaxBytesPerLine)) u_ram_b (
    .clk    (clk),
    .wr_en  (wr_en[2]),
    .wr_addr(mem_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(mem_addr),
    .rd_data(rd_b)
  );

  pcxd_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (res_load),
    .res           (res),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .out_column    (out_column),
    .out_line_index(out_line_index),
    .out_line_end  (out_line_end),
    .out_overrun   (out_overrun),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

[tb/pcx_rle_scanline_decoder_test.sv]
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder_test
// Self-checking bench for the PCX run-length scanline decoder. Compressed
// bytes are queued per phase and driven with random gaps; every accepted byte
// is decoded by a local model into the words it should produce, and each
// output word is compared field by field with the oldest prediction. Phases
// cover chunky, three-plane and four-plane modes at short, odd and maximum
// line lengths, and each phase is padded out to a whole scanline before the
// registers change. One phase holds the output off long enough to back up
// the input.
// ----------------------------------------------------------------------------

module pcx_rle_scanline_decoder_test;
  import pcxd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned PRESS_HOLD  = 400;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      in_byte = 8'h00;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [31:0]     out_data;
  logic [ColW-1:0] out_column;
  logic [15:0]     out_line_index;
  logic            out_line_end;
  logic            out_overrun;
  logic            out_last;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic            cfg_index = REG_BYTES_PER_LINE;
  logic [LenW-1:0] cfg_data = '0;

  pcx_rle_scanline_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .out_column     (out_column),
    .out_line_index (out_line_index),
    .out_line_end   (out_line_end),
    .out_overrun    (out_overrun),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // local decoder state
  logic [LenW-1:0] set_bpl = LEN_RESET;
  logic [1:0]      set_mode = MODE_CHUNKY;
  bit              run_armed;
  logic [5:0]      run_count = '0;
  logic [1:0]      cur_plane = '0;
  int unsigned     cur_col;
  logic [15:0]     lines_done = '0;
  logic [23:0]     plane_mem [MaxBytesPerLine];

  logic [7:0]  stream_q [$];
  result_t     decoded_q [$];

  bit          in_hs;
  bit          calm;
  bit          press_req;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned err_count;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned line_bytes();
    if (set_bpl == '0) return 1;
    if (set_bpl > LEN_MAX) return MaxBytesPerLine;
    return set_bpl;
  endfunction

  function automatic int unsigned plane_count();
    case (set_mode)
      MODE_CHUNKY:  return 1;
      MODE_PLANAR3: return 3;
      default:      return 4;
    endcase
  endfunction

  function automatic logic [31:0] irgb_word(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic [7:0] i);
    logic [31:0] w;
    int hi;
    int lo;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      hi = 7 - 2 * j;
      lo = 6 - 2 * j;
      w[8*j+4 +: 4] = {i[hi], b[hi], g[hi], r[hi]};
      w[8*j +: 4]   = {i[lo], b[lo], g[lo], r[lo]};
    end
    return w;
  endfunction

  function automatic bit place_byte(input logic [7:0] val, output result_t res,
                                    output bit ended);
    int unsigned len;
    int unsigned planes;
    int unsigned col;
    bit top;
    logic [23:0] st;
    len = line_bytes();
    planes = plane_count();
    col = cur_col;
    top = (cur_plane >= planes - 1);
    ended = 1'b0;
    res = '0;
    if (!top) begin
      plane_mem[col][8*int'(cur_plane) +: 8] = val;
    end else begin
      st = plane_mem[col];
      if (planes == 1) res.data = {24'h0, val};
      else if (planes == 3) res.data = irgb_word(st[7:0], st[15:8], val, FULL_BYTE);
      else res.data = irgb_word(st[7:0], st[15:8], st[23:16], val);
      res.column = col[ColW-1:0];
      res.line_index = lines_done;
    end
    if (col + 1 >= len) begin
      cur_col = 0;
      if (top) begin
        cur_plane = '0;
        lines_done = lines_done + 16'd1;
        res.line_end = 1'b1;
        ended = 1'b1;
      end else begin
        cur_plane = cur_plane + 2'd1;
      end
    end else begin
      cur_col = col + 1;
    end
    return top;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    int unsigned reps;
    result_t res;
    bit ended;
    bit made;
    result_t batch [$];
    if (run_armed) begin
      reps = run_count;
      run_armed = 1'b0;
      run_count = '0;
    end else if ((b & RUN_MARK) == RUN_MARK) begin
      run_armed = 1'b1;
      run_count = b[5:0];
      return;
    end else begin
      reps = 1;
    end
    for (int unsigned k = 0; k < reps; k++) begin
      made = place_byte(b, res, ended);
      if (ended && k + 1 < reps) res.overrun = 1'b1;
      if (made) batch.push_back(res);
      if (ended && k + 1 < reps) break;
    end
    if (batch.size() != 0) begin
      batch[$].last = 1'b1;
      foreach (batch[n]) decoded_q.push_back(batch[n]);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
    err_count++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sample outputs, track register writes, decode accepted bytes
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      in_hs = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected word", out_data, 32'h0);
        end else begin
          want = decoded_q.pop_front();
          if (out_data !== want.data) report_mismatch("data", out_data, want.data);
          if (out_column !== want.column)
            report_mismatch("column", 32'(out_column), 32'(want.column));
          if (out_line_index !== want.line_index)
            report_mismatch("line_index", 32'(out_line_index), 32'(want.line_index));
          if (out_line_end !== want.line_end)
            report_mismatch("line_end", 32'(out_line_end), 32'(want.line_end));
          if (out_overrun !== want.overrun)
            report_mismatch("overrun", 32'(out_overrun), 32'(want.overrun));
          if (out_last !== want.last)
            report_mismatch("last", 32'(out_last), 32'(want.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BYTES_PER_LINE) set_bpl = cfg_data;
        else set_mode = cfg_data[1:0];
      end
      in_hs = in_valid && in_ready;
      if (in_hs) decode_byte(in_byte);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_hs) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        in_byte <= stream_q.pop_front();
        in_valid <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output receiver
  always @(negedge clk) begin
    if (press_req) begin
      press_req = 1'b0;
      hold_left = PRESS_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (calm || $urandom_range(0, 99) < 65) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      hold_left = pick_gap();
    end
  end

  task automatic wait_idle();
    while (stream_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [LenW-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic start_phase(input logic [LenW-1:0] bpl, input logic [1:0] mode,
                             input bit quiet);
    write_reg(REG_BYTES_PER_LINE, bpl);
    write_reg(REG_PLANE_MODE, LenW'(mode));
    @(posedge clk);
    calm = quiet;
  endtask

  task automatic push_random(input int unsigned n);
    int unsigned sent;
    int unsigned r;
    int unsigned cnt;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        r = $urandom_range(0, 99);
        if (r < 10) cnt = 0;
        else if (r < 55) cnt = $urandom_range(1, 6);
        else if (r < 85) cnt = $urandom_range(7, 40);
        else cnt = $urandom_range(41, 63);
        stream_q.push_back(RUN_MARK | 8'(cnt));
        stream_q.push_back(8'($urandom_range(0, 255)));
        sent += 2;
      end else if (r < 92) begin
        stream_q.push_back(8'($urandom_range(0, 8'hBF)));
        sent++;
      end else begin
        stream_q.push_back(8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  // pad with runs until the scanline is complete
  task automatic close_line();
    int unsigned left;
    forever begin
      while (stream_q.size() != 0 || in_valid) @(posedge clk);
      if (run_armed) begin
        stream_q.push_back(8'($urandom_range(0, 255)));
      end else if (cur_col == 0 && cur_plane == '0) begin
        break;
      end else begin
        left = (plane_count() - 1 - cur_plane) * line_bytes() + (line_bytes() - cur_col);
        stream_q.push_back(RUN_MARK | 8'((left > 63) ? 63 : left));
        stream_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    foreach (plane_mem[n]) plane_mem[n] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: plain literals
    stream_q = '{8'h00, 8'hBF, 8'h41};
    close_line();

    // chunky: zero count, run cut at line end, header value via run
    start_phase(LenW'(5), MODE_CHUNKY, 1'b0);
    stream_q = '{8'hC0, 8'h12, 8'hFF, 8'hFF, 8'hC1, 8'hC0, 8'h3C};
    push_random(30);
    close_line();

    // three planes, blue last; run crossing planes and cut at line end
    start_phase(LenW'(2), MODE_PLANAR3, 1'b0);
    stream_q = '{8'hA5, 8'h5A, 8'hC1, 8'h0F, 8'hF0, 8'h33, 8'hC1, 8'hCC, 8'hC8, 8'h99};
    push_random(30);
    close_line();

    start_phase(LenW'(3), MODE_PLANAR4, 1'b0);
    stream_q = '{8'hC3, 8'hFF, 8'h55, 8'hAA, 8'h00, 8'hC3, 8'h0F, 8'h81, 8'h7E, 8'hBD};
    push_random(40);
    close_line();

    // zero length reads as one, spare mode as four planes
    start_phase('0, MODE_SPARE, 1'b0);
    push_random(30);
    close_line();

    // no gaps, long output hold-off to back up the input
    start_phase(LenW'(1), MODE_CHUNKY, 1'b1);
    press_req = 1'b1;
    push_random(40);
    close_line();

    start_phase('1, MODE_CHUNKY, 1'b0);
    push_random(20);
    close_line();

    start_phase(LEN_MAX, MODE_PLANAR3, 1'b0);
    push_random(10);
    close_line();

    start_phase(LenW'(7), MODE_CHUNKY, 1'b0);
    push_random(40);
    close_line();

    wait_idle();
    repeat (20) @(posedge clk);
    if (decoded_q.size() != 0) report_mismatch("missing words", decoded_q.size(), 32'h0);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
